[rtl/gss_pkg.sv]
// Shared types, constants and codes for the golden-section search block.
`timescale 1ns / 1ps

package gss_pkg;

  localparam int DataW      = 32;
  localparam int WideW      = DataW + 1;
  localparam int StepW      = WideW + 1;
  localparam int RatioBits  = 16;
  localparam int ProdW      = WideW + RatioBits;
  localparam int CountW     = 17;
  localparam int TolW       = 31;
  localparam int BudgetW    = 16;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = TolW;
  localparam int QueueDepth = 2;

  // (sqrt(5)-1)/2 in unsigned Q0.16
  localparam logic [RatioBits-1:0] RatioQ = 16'd40503;

  localparam logic [TolW-1:0]    TolReset    = 31'd66;
  localparam logic [BudgetW-1:0] BudgetReset = 16'd1000;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_VALUE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_SEARCH = 2'd0,
    ST_CONV   = 2'd1,
    ST_EXCEED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOL    = 1'b0,
    CFG_BUDGET = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_SECOND = 3'd2,
    PH_LEFT   = 3'd3,
    PH_RIGHT  = 3'd4,
    PH_MID    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CS_TAKE  = 2'd0,
    CS_ITER  = 2'd1,
    CS_MUL   = 2'd2,
    CS_PROBE = 2'd3
  } core_state_e;

  typedef enum logic [1:0] {
    PS_BOTH  = 2'd0,
    PS_LEFT  = 2'd1,
    PS_RIGHT = 2'd2
  } probe_sel_e;

  typedef struct packed {
    kind_e kind;
    data_t lower;
    data_t upper;
    data_t fvalue;
  } in_item_t;

  typedef struct packed {
    logic              done_res;
    data_t             point;
    status_e           status;
    data_t             best_value;
    logic [CountW-1:0] calls_used;
  } out_item_t;

  // classified word between front queue and core
  typedef struct packed {
    logic  start;
    data_t a;     // lower on start, objective value otherwise
    data_t b;     // upper on start
  } cmd_t;

  typedef struct packed {
    logic [TolW-1:0]    tolerance;
    logic [BudgetW-1:0] call_budget;
  } cfg_t;

endpackage

[rtl/gss_queue.sv]
// Front end: accepts input words, classifies them and queues them for the core.
`timescale 1ns / 1ps

module gss_queue import gss_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;
  cmd_t            cmd_in;

  assign in_ready  = (count != FullCnt);
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = slots[rd_ptr];

  always_comb begin
    cmd_in.start = (in_data.kind == KIND_START);
    cmd_in.a     = cmd_in.start ? in_data.lower : in_data.fvalue;
    cmd_in.b     = in_data.upper;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[rtl/gss_core.sv]
// Back end: search state, interval narrowing, ratio multiply and result generation.
`timescale 1ns / 1ps

module gss_core import gss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  core_state_e       state, state_next;
  phase_e            phase, phase_next;
  logic [CountW-1:0] call_count, call_count_next;
  data_t             low_end, low_end_next;
  data_t             high_end, high_end_next;
  data_t             left_probe, left_probe_next;
  data_t             right_probe, right_probe_next;
  data_t             left_value, left_value_next;
  data_t             right_value, right_value_next;
  wide_t             width, width_next;
  logic [WideW-1:0]  ratio, ratio_next;
  logic              neg, neg_next;
  probe_sel_e        psel, psel_next;

  logic [CountW-1:0]       count_bump;
  wide_t                   diff;
  wide_t                   sum;
  data_t                   mid;
  logic                    narrow;
  logic                    over_budget;
  logic [WideW-1:0]        mag;
  logic [ProdW-1:0]        prod;
  logic signed [StepW-1:0] step;
  logic signed [StepW-1:0] lp_full;
  logic signed [StepW-1:0] rp_full;
  data_t                   lp;
  data_t                   rp;

  always_comb begin
    count_bump  = (call_count == '1) ? call_count : call_count + CountW'(1);
    diff        = {high_end[DataW-1], high_end} - {low_end[DataW-1], low_end};
    sum         = {high_end[DataW-1], high_end} + {low_end[DataW-1], low_end};
    mid         = sum[WideW-1:1];  // floor of the half sum
    narrow      = $signed({diff[WideW-1], diff}) <
                  $signed({{(StepW-TolW){1'b0}}, cfg.tolerance});
    over_budget = call_count > {{(CountW-BudgetW){1'b0}}, cfg.call_budget};
    mag         = width[WideW-1] ? WideW'(-width) : WideW'(width);
    prod        = ProdW'(mag) * ProdW'(RatioQ);
    step        = neg ? -$signed({1'b0, ratio}) : $signed({1'b0, ratio});
    lp_full     = $signed({{2{high_end[DataW-1]}}, high_end}) - step;
    rp_full     = $signed({{2{low_end[DataW-1]}}, low_end}) + step;
    lp          = lp_full[DataW-1:0];
    rp          = rp_full[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CS_TAKE;
      phase      <= PH_IDLE;
      call_count <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      call_count <= call_count_next;
    end
  end

  always_ff @(posedge clk) begin
    low_end     <= low_end_next;
    high_end    <= high_end_next;
    left_probe  <= left_probe_next;
    right_probe <= right_probe_next;
    left_value  <= left_value_next;
    right_value <= right_value_next;
    width       <= width_next;
    ratio       <= ratio_next;
    neg         <= neg_next;
    psel        <= psel_next;
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    call_count_next  = call_count;
    low_end_next     = low_end;
    high_end_next    = high_end;
    left_probe_next  = left_probe;
    right_probe_next = right_probe;
    left_value_next  = left_value;
    right_value_next = right_value;
    width_next       = width;
    ratio_next       = ratio;
    neg_next         = neg;
    psel_next        = psel;
    cmd_ready        = 1'b0;
    res_valid        = 1'b0;
    res              = '0;
    res.status       = ST_SEARCH;

    unique case (state)
      CS_TAKE: begin
        if (cmd_valid) begin
          if (cmd.start) begin
            cmd_ready        = 1'b1;
            low_end_next     = cmd.a;
            high_end_next    = cmd.b;
            width_next       = {cmd.b[DataW-1], cmd.b} - {cmd.a[DataW-1], cmd.a};
            left_value_next  = '0;
            right_value_next = '0;
            call_count_next  = CountW'(1);
            phase_next       = PH_FIRST;
            psel_next        = PS_BOTH;
            state_next       = CS_MUL;
          end else begin
            unique case (phase)
              PH_FIRST: begin
                if (res_ready) begin
                  cmd_ready       = 1'b1;
                  left_value_next = cmd.a;
                  call_count_next = count_bump;
                  phase_next      = PH_SECOND;
                  res_valid       = 1'b1;
                  res.point       = right_probe;
                  res.calls_used  = count_bump;
                end
              end
              PH_SECOND, PH_RIGHT: begin
                cmd_ready        = 1'b1;
                right_value_next = cmd.a;
                state_next       = CS_ITER;
              end
              PH_LEFT: begin
                cmd_ready       = 1'b1;
                left_value_next = cmd.a;
                state_next      = CS_ITER;
              end
              PH_MID: begin
                if (res_ready) begin
                  cmd_ready      = 1'b1;
                  phase_next     = PH_IDLE;
                  res_valid      = 1'b1;
                  res.done_res   = 1'b1;
                  res.point      = mid;
                  res.status     = ST_CONV;
                  res.best_value = cmd.a;
                  res.calls_used = call_count;
                end
              end
              default: begin
                // value with no search running is dropped
                cmd_ready = 1'b1;
              end
            endcase
          end
        end
      end

      CS_ITER: begin
        if (over_budget) begin
          if (res_ready) begin
            phase_next     = PH_IDLE;
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.status     = ST_EXCEED;
            res.calls_used = call_count;
            state_next     = CS_TAKE;
          end
        end else if (narrow) begin
          if (res_ready) begin
            call_count_next = count_bump;
            phase_next      = PH_MID;
            res_valid       = 1'b1;
            res.point       = mid;
            res.calls_used  = count_bump;
            state_next      = CS_TAKE;
          end
        end else if (left_value < right_value) begin
          high_end_next    = right_probe;
          right_probe_next = left_probe;
          right_value_next = left_value;
          width_next       = {right_probe[DataW-1], right_probe} -
                             {low_end[DataW-1], low_end};
          call_count_next  = count_bump;
          phase_next       = PH_LEFT;
          psel_next        = PS_LEFT;
          state_next       = CS_MUL;
        end else begin
          low_end_next     = left_probe;
          left_probe_next  = right_probe;
          left_value_next  = right_value;
          width_next       = {high_end[DataW-1], high_end} -
                             {left_probe[DataW-1], left_probe};
          call_count_next  = count_bump;
          phase_next       = PH_RIGHT;
          psel_next        = PS_RIGHT;
          state_next       = CS_MUL;
        end
      end

      CS_MUL: begin
        // ratio applied to the magnitude, truncated toward zero
        ratio_next = prod[ProdW-1:RatioBits];
        neg_next   = width[WideW-1];
        state_next = CS_PROBE;
      end

      CS_PROBE: begin
        if (res_ready) begin
          res_valid      = 1'b1;
          res.calls_used = call_count;
          state_next     = CS_TAKE;
          unique case (psel)
            PS_BOTH: begin
              left_probe_next  = lp;
              right_probe_next = rp;
              res.point        = lp;
            end
            PS_LEFT: begin
              left_probe_next = lp;
              res.point       = lp;
            end
            default: begin
              right_probe_next = rp;
              res.point        = rp;
            end
          endcase
        end
      end

      default: begin
        state_next = CS_TAKE;
      end
    endcase
  end

endmodule

[rtl/golden_section_search.sv]
// Golden-section search: one input word per cycle into a queue while the queue has room,
// one result word out. Results come from core states: the second-probe request and the
// final answer from the take state, a midpoint request or a budget stop from the iterate
// state, a start via multiply and probe, a narrowing step via iterate, multiply and probe.
// Words are taken every cycle until the 2-entry queue fills, so new words enter while the core still works on the last.
// Reset (rst, synchronous): queue empty, search idle, tolerance 66, call budget 1000.
`timescale 1ns / 1ps

module golden_section_search import gss_pkg::*; #(
  parameter int QueueDepth = gss_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t      cfg;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_t      cmd;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance   <= TolReset;
      cfg.call_budget <= BudgetReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_TOL:    cfg.tolerance   <= cfg_data[TolW-1:0];
        CFG_BUDGET: cfg.call_budget <= cfg_data[BudgetW-1:0];
        default:    ;
      endcase
    end
  end

  gss_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  gss_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register; while a word waits here the core stalls only in states that emit a result
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

endmodule

[rtl/gss_checker.sv]
// Port-level checks on the result channel of the golden-section search.
`timescale 1ns / 1ps

module gss_checker import gss_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_request_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |->
      out_data.status == ST_SEARCH && out_data.best_value == '0)
    else $error("point request with final status or value");

  a_final_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |->
      out_data.status == ST_CONV || out_data.status == ST_EXCEED)
    else $error("final answer with searching status");

  a_exceed_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EXCEED |->
      out_data.done_res && out_data.point == '0 && out_data.best_value == '0)
    else $error("budget exceeded word not cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind golden_section_search gss_checker u_gss_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
